// ----- sv/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

    localparam int CNT_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 3;
    localparam int HOLD_N  = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 16'hFFFF;

    // pending count codes
    localparam logic [PEND_W-1:0] PC_NONE = 3'd0;
    localparam logic [PEND_W-1:0] PC_BSL  = 3'd1;
    localparam logic [PEND_W-1:0] PC_U    = 3'd2;
    localparam logic [PEND_W-1:0] PC_H1   = 3'd3;
    localparam logic [PEND_W-1:0] PC_H2   = 3'd4;
    localparam logic [PEND_W-1:0] PC_FULL = 3'd5;

    localparam logic [BYTE_W-1:0] C_BSL = 8'h5C;
    localparam logic [BYTE_W-1:0] C_QUO = 8'h22;
    localparam logic [BYTE_W-1:0] C_U   = 8'h75;
    localparam logic [BYTE_W-1:0] C_B   = 8'h62;
    localparam logic [BYTE_W-1:0] C_F   = 8'h66;
    localparam logic [BYTE_W-1:0] C_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] C_R   = 8'h72;
    localparam logic [BYTE_W-1:0] C_T   = 8'h74;
    localparam logic [BYTE_W-1:0] C_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] C_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] C_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] C_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] C_TAB = 8'h09;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CUR,
        S_REP_U,
        S_HELD
    } t_state;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_CUR,
        SRC_U,
        SRC_HELD
    } t_src;

    typedef struct packed {
        logic go;
        logic latch_cur;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic done;
        logic replay;
        logic consume;
        logic has_held;
        logic held_last;
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/json_string_unescape_core.sv -----
`default_nettype none
// JSON string body unescaper.
// Input channel (i_in_valid / o_in_ready) takes one raw byte per item with
// i_end_of_string on the final byte of a string. Output channel
// (o_out_valid / i_out_ready) gives unescaped bytes with o_last on the final
// result of a string and o_total_length counting bytes emitted so far.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the output
// capacity; write it only while the block is idle.
// Latency: a result appears in the output register the cycle after the item
// that causes it is processed.
// Throughput: one item per cycle for plain bytes and completed escapes while
// the output is free. The byte after a backslash that is not a known escape
// is taken twice; new input waits until then. A final byte that cuts a \u
// escape short replays backslash, 'u', each held digit and the final byte,
// also taking twice any held byte that needs it and replaying again when the
// held digits open another \u escape; at most one result per cycle.
// Reset (synchronous, active low) empties the output register, clears the
// escape and length state and sets the capacity to 65535.
// When the receiver stalls, the output register holds its result and
// o_in_ready drops until the result is taken.
module json_string_unescape_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [jsu_pkg::BYTE_W-1:0]   i_in_byte,
    input  wire logic                         i_end_of_string,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [jsu_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_overflow_error,
    output logic                              o_last,
    output logic [jsu_pkg::CNT_W-1:0]         o_total_length,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [jsu_pkg::CNT_W-1:0]    i_cfg_data
);

    jsu_pkg::t_cmd  cmd;
    jsu_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    jsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    jsu_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_in_byte        (i_in_byte),
        .i_end_of_string  (i_end_of_string),
        .i_cfg_valid      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_overflow_error (o_overflow_error),
        .o_last           (o_last),
        .o_total_length   (o_total_length)
    );

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow_error |-> o_last && (o_out_byte == 8'd0))
        else $error("error result without last or with nonzero byte");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_overflow_error |-> o_total_length != 16'd0)
        else $error("data result with zero length");

    a_held_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.src == jsu_pkg::SRC_HELD |-> stat.has_held)
        else $error("replaying held bytes with none held");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (cmd.src == jsu_pkg::SRC_IN) && stat.out_free)
        else $error("input ready while busy");

endmodule

`default_nettype wire

// ----- sv/jsu_ctrl.sv -----
`default_nettype none

module jsu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  jsu_pkg::t_stat      i_stat,
    output jsu_pkg::t_cmd       o_cmd,
    output logic                o_in_ready
);

    jsu_pkg::t_state r_state;
    jsu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jsu_pkg::S_IDLE: begin
                if (i_in_valid && i_stat.out_free && !i_stat.done) begin
                    n_state = i_stat.replay ? jsu_pkg::S_REP_U : jsu_pkg::S_CUR;
                end
            end
            jsu_pkg::S_CUR: begin
                if (i_stat.out_free) begin
                    if (i_stat.done) begin
                        n_state = jsu_pkg::S_IDLE;
                    end else if (i_stat.replay) begin
                        n_state = jsu_pkg::S_REP_U;
                    end
                end
            end
            jsu_pkg::S_REP_U: begin
                if (i_stat.out_free) begin
                    if (i_stat.done) begin
                        n_state = jsu_pkg::S_IDLE;
                    end else if (i_stat.has_held) begin
                        n_state = jsu_pkg::S_HELD;
                    end else begin
                        n_state = jsu_pkg::S_CUR;
                    end
                end
            end
            jsu_pkg::S_HELD: begin
                if (i_stat.out_free) begin
                    if (i_stat.done) begin
                        n_state = jsu_pkg::S_IDLE;
                    end else if (i_stat.consume && i_stat.held_last) begin
                        n_state = jsu_pkg::S_CUR;
                    end
                end
            end
            default: n_state = jsu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.go        = 1'b0;
        o_cmd.latch_cur = 1'b0;
        o_cmd.src       = jsu_pkg::SRC_IN;
        o_in_ready      = 1'b0;
        unique case (r_state)
            jsu_pkg::S_IDLE: begin
                o_cmd.src       = jsu_pkg::SRC_IN;
                o_in_ready      = i_stat.out_free;
                o_cmd.go        = i_stat.out_free && i_in_valid;
                o_cmd.latch_cur = i_stat.out_free && i_in_valid;
            end
            jsu_pkg::S_CUR: begin
                o_cmd.src = jsu_pkg::SRC_CUR;
                o_cmd.go  = i_stat.out_free;
            end
            jsu_pkg::S_REP_U: begin
                o_cmd.src = jsu_pkg::SRC_U;
                o_cmd.go  = i_stat.out_free;
            end
            jsu_pkg::S_HELD: begin
                o_cmd.src = jsu_pkg::SRC_HELD;
                o_cmd.go  = i_stat.out_free;
            end
            default: begin
                o_cmd.src = jsu_pkg::SRC_IN;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/jsu_dpath.sv -----
`default_nettype none

module jsu_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  jsu_pkg::t_cmd                     i_cmd,
    output jsu_pkg::t_stat                    o_stat,
    input  wire logic [jsu_pkg::BYTE_W-1:0]   i_in_byte,
    input  wire logic                         i_end_of_string,
    input  wire logic                         i_cfg_valid,
    input  wire logic [jsu_pkg::CNT_W-1:0]    i_cfg_data,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [jsu_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_overflow_error,
    output logic                              o_last,
    output logic [jsu_pkg::CNT_W-1:0]         o_total_length
);

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {valid, code}
    function automatic logic [8:0] short_code(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            jsu_pkg::C_QUO: r = {1'b1, jsu_pkg::C_QUO};
            jsu_pkg::C_BSL: r = {1'b1, jsu_pkg::C_BSL};
            jsu_pkg::C_B:   r = {1'b1, jsu_pkg::C_BS};
            jsu_pkg::C_F:   r = {1'b1, jsu_pkg::C_FF};
            jsu_pkg::C_N:   r = {1'b1, jsu_pkg::C_LF};
            jsu_pkg::C_R:   r = {1'b1, jsu_pkg::C_CR};
            jsu_pkg::C_T:   r = {1'b1, jsu_pkg::C_TAB};
            default:        r = 9'd0;
        endcase
        return r;
    endfunction

    logic [jsu_pkg::CNT_W-1:0]  r_cap;
    logic [jsu_pkg::PEND_W-1:0] r_pcnt;
    logic [jsu_pkg::CNT_W-1:0]  r_emitted;
    logic                       r_dropping;
    logic [jsu_pkg::BYTE_W-1:0] r_pend [0:jsu_pkg::HOLD_N-1];
    logic [jsu_pkg::BYTE_W-1:0] r_cur_byte;
    logic                       r_cur_fin;
    logic [1:0]                 r_ridx;
    logic [1:0]                 r_hcnt;
    logic                       r_out_valid;
    logic [jsu_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_err;
    logic                       r_out_last;
    logic [jsu_pkg::CNT_W-1:0]  r_out_len;

    logic [jsu_pkg::BYTE_W-1:0] sb;
    logic                       sf;
    logic                       fin_src;
    logic [jsu_pkg::PEND_W-1:0] n_pcnt;
    logic [jsu_pkg::PEND_W-1:0] pidx;
    logic [jsu_pkg::PEND_W-1:0] hsub;
    logic                       consume;
    logic                       replay;
    logic                       pend_we;
    logic                       emit_req;
    logic [jsu_pkg::BYTE_W-1:0] emit_val;
    logic [jsu_pkg::CNT_W:0]    sum;
    logic                       over;
    logic                       err;
    logic                       emit_ok;
    logic                       done;
    logic                       last;
    logic                       out_free;
    logic [8:0]                 sc;
    logic [4:0]                 h0, h1, h2, h3;
    logic [7:0]                 hex_byte;

    assign out_free = !r_out_valid || i_out_ready;
    assign pidx     = r_pcnt - jsu_pkg::PC_U;
    assign hsub     = r_pcnt - jsu_pkg::PC_U;

    always_comb begin
        case (i_cmd.src)
            jsu_pkg::SRC_IN: begin
                sb = i_in_byte;
                sf = i_end_of_string;
            end
            jsu_pkg::SRC_CUR: begin
                sb = r_cur_byte;
                sf = r_cur_fin;
            end
            jsu_pkg::SRC_HELD: begin
                sb = r_pend[r_ridx];
                sf = 1'b0;
            end
            default: begin
                sb = jsu_pkg::C_U;
                sf = 1'b0;
            end
        endcase
    end

    assign fin_src = (i_cmd.src == jsu_pkg::SRC_IN) ? i_end_of_string : r_cur_fin;

    assign sc = short_code(sb);
    assign h0 = hex_val(r_pend[0]);
    assign h1 = hex_val(r_pend[1]);
    assign h2 = hex_val(r_pend[2]);
    assign h3 = hex_val(sb);

    // low byte of the leading hex-digit run
    always_comb begin
        if (!h0[4]) begin
            hex_byte = 8'd0;
        end else if (!h1[4]) begin
            hex_byte = {4'd0, h0[3:0]};
        end else if (!h2[4]) begin
            hex_byte = {h0[3:0], h1[3:0]};
        end else if (!h3[4]) begin
            hex_byte = {h1[3:0], h2[3:0]};
        end else begin
            hex_byte = {h2[3:0], h3[3:0]};
        end
    end

    always_comb begin
        consume  = 1'b0;
        replay   = 1'b0;
        pend_we  = 1'b0;
        emit_req = 1'b0;
        emit_val = sb;
        n_pcnt   = r_pcnt;
        if (i_cmd.src == jsu_pkg::SRC_U) begin
            emit_req = 1'b1;
            emit_val = jsu_pkg::C_U;
        end else if (r_dropping) begin
            consume = 1'b1;
        end else begin
            case (r_pcnt)
                jsu_pkg::PC_NONE: begin
                    consume = 1'b1;
                    if (sb == jsu_pkg::C_BSL && !sf) begin
                        n_pcnt = jsu_pkg::PC_BSL;
                    end else begin
                        emit_req = 1'b1;
                    end
                end
                jsu_pkg::PC_BSL: begin
                    if (sc[8]) begin
                        consume  = 1'b1;
                        emit_req = 1'b1;
                        emit_val = sc[7:0];
                        n_pcnt   = jsu_pkg::PC_NONE;
                    end else if (sb == jsu_pkg::C_U && !sf) begin
                        consume = 1'b1;
                        n_pcnt  = jsu_pkg::PC_U;
                    end else begin
                        // backslash goes out as is, this byte is taken again
                        emit_req = 1'b1;
                        emit_val = jsu_pkg::C_BSL;
                        n_pcnt   = jsu_pkg::PC_NONE;
                    end
                end
                jsu_pkg::PC_U, jsu_pkg::PC_H1, jsu_pkg::PC_H2: begin
                    if (!sf) begin
                        consume = 1'b1;
                        pend_we = 1'b1;
                        n_pcnt  = r_pcnt + 3'd1;
                    end else begin
                        replay   = 1'b1;
                        emit_req = 1'b1;
                        emit_val = jsu_pkg::C_BSL;
                        n_pcnt   = jsu_pkg::PC_NONE;
                    end
                end
                jsu_pkg::PC_FULL: begin
                    consume  = 1'b1;
                    emit_req = 1'b1;
                    emit_val = hex_byte;
                    n_pcnt   = jsu_pkg::PC_NONE;
                end
                default: begin
                    consume = 1'b1;
                    n_pcnt  = jsu_pkg::PC_NONE;
                end
            endcase
        end
    end

    assign sum     = {1'b0, r_emitted} + 17'd1;
    assign over    = sum >= {1'b0, r_cap};
    assign err     = emit_req && over;
    assign emit_ok = emit_req && !over;
    assign done    = err || (consume && (i_cmd.src == jsu_pkg::SRC_IN ||
                                         i_cmd.src == jsu_pkg::SRC_CUR));
    assign last    = consume && sf;

    assign o_stat.out_free  = out_free;
    assign o_stat.done      = done;
    assign o_stat.replay    = replay;
    assign o_stat.consume   = consume;
    assign o_stat.has_held  = r_hcnt != 2'd0;
    assign o_stat.held_last = (r_ridx + 2'd1) == r_hcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= jsu_pkg::CAP_RESET;
            r_pcnt      <= jsu_pkg::PC_NONE;
            r_emitted   <= '0;
            r_dropping  <= 1'b0;
            r_ridx      <= 2'd0;
            r_hcnt      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.go && (emit_ok || err)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.go) begin
                if (done && fin_src) begin
                    r_pcnt     <= jsu_pkg::PC_NONE;
                    r_emitted  <= '0;
                    r_dropping <= 1'b0;
                end else if (err) begin
                    r_pcnt     <= jsu_pkg::PC_NONE;
                    r_dropping <= 1'b1;
                end else begin
                    r_pcnt <= n_pcnt;
                    if (emit_ok) begin
                        r_emitted <= sum[jsu_pkg::CNT_W-1:0];
                    end
                end
                if (replay) begin
                    r_hcnt <= hsub[1:0];
                end
                if (i_cmd.src == jsu_pkg::SRC_U) begin
                    r_ridx <= 2'd0;
                end else if (i_cmd.src == jsu_pkg::SRC_HELD && consume) begin
                    r_ridx <= r_ridx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_cur) begin
            r_cur_byte <= i_in_byte;
            r_cur_fin  <= i_end_of_string;
        end
        if (i_cmd.go && pend_we) begin
            r_pend[pidx[1:0]] <= sb;
        end
        if (i_cmd.go && (emit_ok || err)) begin
            r_out_byte <= err ? '0 : emit_val;
            r_out_err  <= err;
            r_out_last <= err || last;
            r_out_len  <= err ? r_emitted : sum[jsu_pkg::CNT_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_overflow_error = r_out_err;
    assign o_last           = r_out_last;
    assign o_total_length   = r_out_len;

endmodule

`default_nettype wire

// ----- tb/sv/tb_json_string_unescape_core.sv -----
`default_nettype none

module tb_json_string_unescape_core;

    localparam int MAX_RES    = 5;
    localparam int HOLD_DEPTH = 5;

    typedef logic [jsu_pkg::BYTE_W-1:0] t_byte_stream[$];

    typedef struct packed {
        logic [jsu_pkg::BYTE_W-1:0] data;
        logic                       err;
        logic                       last;
        logic [jsu_pkg::CNT_W-1:0]  len;
    } t_unesc_out;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [jsu_pkg::BYTE_W-1:0]  i_in_byte;
    logic                        i_end_of_string;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [jsu_pkg::BYTE_W-1:0]  o_out_byte;
    logic                        o_overflow_error;
    logic                        o_last;
    logic [jsu_pkg::CNT_W-1:0]   o_total_length;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [jsu_pkg::CNT_W-1:0]   i_cfg_data;

    json_string_unescape_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_end_of_string  (i_end_of_string),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_overflow_error (o_overflow_error),
        .o_last           (o_last),
        .o_total_length   (o_total_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor state
    logic [jsu_pkg::CNT_W-1:0]  cap_now       = jsu_pkg::CAP_RESET;
    logic [jsu_pkg::BYTE_W-1:0] esc_held[HOLD_DEPTH];
    int                         esc_held_n    = 0;
    logic [jsu_pkg::CNT_W-1:0]  emitted_len   = '0;
    bit                         dropping_rest = 1'b0;

    t_unesc_out unescaped_q[$];
    t_unesc_out step_res[$];

    int errors         = 0;
    int live_items     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    function automatic void emit_unescaped(input logic [jsu_pkg::BYTE_W-1:0] b);
        if (dropping_rest)
            return;
        if ({1'b0, emitted_len} + 17'd1 >= {1'b0, cap_now}) begin
            if (step_res.size() < MAX_RES)
                step_res.push_back('{8'h00, 1'b1, 1'b1, emitted_len});
            dropping_rest = 1'b1;
            esc_held_n = 0;
            return;
        end
        emitted_len = emitted_len + 16'd1;
        if (step_res.size() < MAX_RES)
            step_res.push_back('{b, 1'b0, 1'b0, emitted_len});
    endfunction

    function automatic int escape_char(input logic [jsu_pkg::BYTE_W-1:0] c);
        case (c)
            jsu_pkg::C_QUO: return jsu_pkg::C_QUO;
            jsu_pkg::C_BSL: return jsu_pkg::C_BSL;
            jsu_pkg::C_B:   return jsu_pkg::C_BS;
            jsu_pkg::C_F:   return jsu_pkg::C_FF;
            jsu_pkg::C_N:   return jsu_pkg::C_LF;
            jsu_pkg::C_R:   return jsu_pkg::C_CR;
            jsu_pkg::C_T:   return jsu_pkg::C_TAB;
            default:        return -1;
        endcase
    endfunction

    function automatic int hex_digit(input logic [jsu_pkg::BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void unescape_byte(input logic [jsu_pkg::BYTE_W-1:0] b,
                                          input bit fin);
        int                         k;
        int                         d;
        int                         n;
        logic [jsu_pkg::BYTE_W-1:0] v;
        logic [jsu_pkg::BYTE_W-1:0] saved[HOLD_DEPTH];
        if (dropping_rest)
            return;
        if (esc_held_n == 0) begin
            if (b == jsu_pkg::C_BSL && !fin) begin
                esc_held[0] = b;
                esc_held_n = 1;
            end else begin
                emit_unescaped(b);
            end
        end else if (esc_held_n == 1) begin
            k = escape_char(b);
            if (k >= 0) begin
                esc_held_n = 0;
                emit_unescaped(k[jsu_pkg::BYTE_W-1:0]);
            end else if (b == jsu_pkg::C_U && !fin) begin
                esc_held[1] = b;
                esc_held_n = 2;
            end else begin
                esc_held_n = 0;
                emit_unescaped(jsu_pkg::C_BSL);
                unescape_byte(b, fin);
            end
        end else if (esc_held_n >= HOLD_DEPTH) begin
            v = '0;
            for (int i = 0; i < 4; i++) begin
                d = hex_digit(i < 3 ? esc_held[i+2] : b);
                if (d < 0)
                    break;
                v = {v[3:0], d[3:0]};
            end
            esc_held_n = 0;
            emit_unescaped(v);
        end else if (!fin) begin
            esc_held[esc_held_n] = b;
            esc_held_n++;
        end else begin
            // \u cut short by end of string: replay what was held
            saved = esc_held;
            n = esc_held_n;
            esc_held_n = 0;
            emit_unescaped(jsu_pkg::C_BSL);
            emit_unescaped(jsu_pkg::C_U);
            for (int i = 2; i < n; i++)
                unescape_byte(saved[i], 1'b0);
            unescape_byte(b, 1'b1);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    initial begin : rx_ready
        int hold_left;
        hold_left = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : mon
        t_unesc_out got;
        t_unesc_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_out_byte, o_overflow_error, o_last, o_total_length};
                if (unescaped_q.size() == 0) begin
                    $error("unexpected result: out_byte %h overflow_error %b last %b total_length %0d",
                           got.data, got.err, got.last, got.len);
                    errors++;
                end else begin
                    want = unescaped_q.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, got.data);
                        errors++;
                    end
                    if (got.err !== want.err) begin
                        $error("overflow_error: expected %b, got %b", want.err, got.err);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        errors++;
                    end
                    if (got.len !== want.len) begin
                        $error("total_length: expected %0d, got %0d", want.len, got.len);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                cap_now = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                live_items++;
                step_res.delete();
                unescape_byte(i_in_byte, i_end_of_string);
                if (i_end_of_string) begin
                    if (step_res.size() > 0)
                        step_res[step_res.size()-1].last = 1'b1;
                    esc_held_n = 0;
                    emitted_len = '0;
                    dropping_rest = 1'b0;
                end
                foreach (step_res[i])
                    unescaped_q.push_back(step_res[i]);
            end
        end
    end

    // all tasks below start and end at a falling edge
    task automatic send_byte(input logic [jsu_pkg::BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_string(input t_byte_stream s, input bit close);
        foreach (s[i])
            send_byte(s[i], close && (i == s.size() - 1));
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (unescaped_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [jsu_pkg::CNT_W-1:0] v);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_byte_stream text_bytes(input string t);
        t_byte_stream q;
        for (int i = 0; i < t.len(); i++)
            q.push_back(t[i]);
        return q;
    endfunction

    function automatic logic [jsu_pkg::BYTE_W-1:0] hex_or_junk();
        string hex_chars;
        hex_chars = "0123456789abcdefABCDEF";
        if ($urandom_range(7) == 0)
            return jsu_pkg::BYTE_W'($urandom_range(255));
        return hex_chars[$urandom_range(21)];
    endfunction

    // mostly well-formed escapes with random content, some noise, and
    // sometimes a final escape cut short by the end of the string
    function automatic t_byte_stream random_string();
        t_byte_stream               s;
        t_byte_stream               tok;
        int                         n_tok;
        int                         cut;
        logic [jsu_pkg::BYTE_W-1:0] esc_set[7];
        esc_set = '{jsu_pkg::C_QUO, jsu_pkg::C_BSL, jsu_pkg::C_B, jsu_pkg::C_F,
                    jsu_pkg::C_N, jsu_pkg::C_R, jsu_pkg::C_T};
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            tok.delete();
            case ($urandom_range(9))
                0, 1, 2: tok.push_back(jsu_pkg::BYTE_W'($urandom_range(255)));
                3, 4: begin
                    tok.push_back(jsu_pkg::C_BSL);
                    tok.push_back(esc_set[$urandom_range(6)]);
                end
                5, 6: begin
                    tok.push_back(jsu_pkg::C_BSL);
                    tok.push_back(jsu_pkg::C_U);
                    repeat (4) tok.push_back(hex_or_junk());
                end
                7: begin
                    tok.push_back(jsu_pkg::C_BSL);
                    tok.push_back(jsu_pkg::BYTE_W'($urandom_range(255)));
                end
                8: begin
                    tok.push_back(jsu_pkg::C_BSL);
                    tok.push_back(jsu_pkg::C_U);
                    repeat (4) tok.push_back(jsu_pkg::BYTE_W'($urandom_range(255)));
                end
                default: tok.push_back(jsu_pkg::BYTE_W'($urandom_range(32, 126)));
            endcase
            if (t == n_tok - 1 && $urandom_range(3) == 0) begin
                cut = $urandom_range(1, tok.size());
                while (tok.size() > cut)
                    void'(tok.pop_back());
            end
            s = {s, tok};
        end
        return s;
    endfunction

    task automatic test_plain_bytes();
        send_string('{8'h00, 8'hFF}, 1'b1);
        send_string(text_bytes("A"), 1'b1);
    endtask

    task automatic test_short_escapes();
        send_string(text_bytes("\\\"\\\\\\b\\f\\n\\r\\t"), 1'b1);
    endtask

    task automatic test_unicode_escapes();
        // full run of digits, digit run stopped by a non-digit, unknown escape
        send_string(text_bytes("\\u4a3F\\u12G4\\qx"), 1'b1);
    endtask

    task automatic test_cut_short_escapes();
        send_string(text_bytes("\\"), 1'b1);
        send_string(text_bytes("\\u"), 1'b1);
        send_string(text_bytes("\\u1"), 1'b1);
        send_string(text_bytes("\\u12\\"), 1'b1);
    endtask

    task automatic test_capacity_limits();
        set_capacity(16'd3);
        send_string(text_bytes("abcd"), 1'b1);
        set_capacity(16'd0);
        send_string(text_bytes("x"), 1'b1);
        set_capacity(16'd1);
        send_string(text_bytes("\\n"), 1'b1);
        // change while a string is open
        set_capacity(jsu_pkg::CAP_RESET);
        send_string(text_bytes("ab"), 1'b0);
        set_capacity(16'd3);
        send_string(text_bytes("cd"), 1'b1);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int goal;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        goal = live_items + n_items;
        while (live_items < goal) begin
            if ($urandom_range(5) == 0) begin
                case ($urandom_range(7))
                    0:       set_capacity(16'd0);
                    1:       set_capacity(16'd1);
                    2:       set_capacity(16'd2);
                    3:       set_capacity(jsu_pkg::CNT_W'($urandom_range(3, 12)));
                    4:       set_capacity(jsu_pkg::CNT_W'($urandom_range(65535)));
                    default: set_capacity(jsu_pkg::CAP_RESET);
                endcase
            end
            send_string(random_string(), 1'b1);
        end
    endtask

    task automatic test_output_backpressure();
        set_capacity(jsu_pkg::CAP_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 80;
        send_string(text_bytes("output held off for a while \\u0041\\n!"), 1'b1);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_byte       = '0;
        i_end_of_string = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 33;
        recv_stall_pct = 74;
        test_plain_bytes();
        test_short_escapes();
        test_unicode_escapes();
        test_cut_short_escapes();
        test_capacity_limits();
        test_random_traffic(33, 74, 125);
        test_random_traffic(74, 33, 125);
        test_random_traffic(0, 0, 125);
        test_output_backpressure();

        drain_block();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
